// ===== hdl/hamming_nearest_capped_match_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the hamming nearest capped match unit
// Each macro expands to a labeled concurrent assertion, or to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HAMMING_NEAREST_CAPPED_MATCH_UNIT_MACROS_SVH
`define HAMMING_NEAREST_CAPPED_MATCH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define HNM_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define HNM_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define HNM_ASSERT_IMPL(label, clk, rst_n, a, c)
`define HNM_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== hdl/hnm_pkg.sv =====
// ----------------------------------------------------------------------------
// hnm_pkg
// Shared types and constants of the nearest capped match unit.
// ----------------------------------------------------------------------------
package hnm_pkg;
    localparam int DESC_BITS_DEF  = 256;
    localparam int MAX_MODELS_DEF = 256;
    localparam int IN_BITS        = 256;
    localparam int DIST_W         = 9;
    localparam int IDX_W          = 8;
    localparam int CNT_W          = 9;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_K_LIMIT      = 2'd0;
    localparam logic [1:0] REG_MODEL_COUNT  = 2'd1;
    localparam logic [1:0] REG_FIRST_COLUMN = 2'd2;

    typedef enum logic [1:0] {
        t_ST_IDLE,
        t_ST_SCAN,
        t_ST_DRAIN,
        t_ST_DECIDE
    } t_state;

    // one beat handed from the front to the back
    typedef struct packed {
        logic                op;
        logic [IDX_W-1:0]    entry_index;
        logic [15:0]         query_id;
        logic [IN_BITS-1:0]  desc;
    } t_item;
endpackage

// ===== hdl/hnm_ram.sv =====
// ----------------------------------------------------------------------------
// hnm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/hnm_front.sv =====
// ----------------------------------------------------------------------------
// hnm_front
// Takes command beats, masks the descriptor and queues them for the back end.
// Two-entry queue.
// ----------------------------------------------------------------------------
module hnm_front
    import hnm_pkg::*;
#(
    parameter int DESC_BITS = DESC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_item       i_item,
    output logic        o_full,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_pop
);
    `include "hamming_nearest_capped_match_unit_macros.svh"

    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    t_item       masked;

    always_comb begin
        masked = i_item;
        masked.desc = i_item.desc & IN_BITS'({DESC_BITS{1'b1}});
    end

    always_comb begin
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= masked;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_q[r_rp];

    `HNM_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, o_full, !i_push)
    `HNM_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, !o_valid, !i_pop)
    `HNM_ASSERT_NEXT(a_cnt_step, i_clk, i_rst_n, i_push && !i_pop, r_cnt != 2'd0)
endmodule

// ===== hdl/hnm_back.sv =====
// ----------------------------------------------------------------------------
// hnm_back
// Executes queued beats: loads write the model RAM, queries scan it one
// entry per cycle and then apply the pick limit.
// ----------------------------------------------------------------------------
module hnm_back
    import hnm_pkg::*;
#(
    parameter int DESC_BITS  = DESC_BITS_DEF,
    parameter int MAX_MODELS = MAX_MODELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    input  logic [7:0]  i_k_limit,
    input  logic [8:0]  i_model_count,
    input  logic [15:0] i_first_column,
    output logic        o_strobe,
    output logic        o_found,
    output logic        o_accepted,
    output logic [7:0]  o_best_entry,
    output logic [8:0]  o_distance,
    output logic [15:0] o_column_number,
    output logic [15:0] o_query_echo
);
    `include "hamming_nearest_capped_match_unit_macros.svh"

    localparam int AW = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;
    localparam int SW = $clog2(MAX_MODELS + 1);

    t_state r_state, n_state;

    logic [AW-1:0]        ram_raddr;
    logic [DESC_BITS-1:0] ram_rdata;
    logic                 load_ok;
    logic                 ld_we;
    logic [AW-1:0]        ld_addr;

    logic [SW-1:0]        r_issue, r_limit;
    logic                 r_rd_v;
    logic [AW-1:0]        r_rd_idx;
    logic [DESC_BITS-1:0] r_qdesc;
    logic [15:0]          r_qid;
    logic [8:0]           r_best_d;
    logic [AW-1:0]        r_best_i;
    logic                 r_any;
    logic [8:0]           cur_d;

    logic [MAX_MODELS-1:0] r_pv;
    logic                  r_pv_hit;
    logic                  pc_we;
    logic [AW-1:0]         pc_waddr;
    logic [7:0]            pc_wdata;
    logic [7:0]            pc_rdata;
    logic [15:0]           r_tally;
    logic [7:0]            pick;
    logic                  acc;

    logic [SW-1:0] lim_sat;
    logic          issue_done;

    assign load_ok = (int'(i_item.entry_index) < MAX_MODELS);
    assign ld_addr = AW'(i_item.entry_index);
    assign ld_we   = (r_state == t_ST_IDLE) && i_valid && i_item.op == OP_LOAD && load_ok;

    assign ram_raddr = AW'(r_issue);

    hnm_ram #(.WIDTH(DESC_BITS), .DEPTH(MAX_MODELS)) u_model (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (ld_addr),
        .i_wdata (i_item.desc[DESC_BITS-1:0]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // pick counts: read at the best index during drain, used in decide
    assign pc_we    = ld_we || (r_state == t_ST_DECIDE && acc);
    assign pc_waddr = ld_we ? ld_addr : r_best_i;
    assign pc_wdata = ld_we ? 8'd0 : pick + 8'd1;

    hnm_ram #(.WIDTH(8), .DEPTH(MAX_MODELS)) u_picks (
        .i_clk   (i_clk),
        .i_we    (pc_we),
        .i_waddr (pc_waddr),
        .i_wdata (pc_wdata),
        .i_raddr (r_best_i),
        .o_rdata (pc_rdata)
    );

    always_comb begin
        if (int'(i_model_count) > MAX_MODELS) lim_sat = SW'(MAX_MODELS);
        else                                  lim_sat = SW'(i_model_count);
    end

    assign issue_done = r_issue >= r_limit;
    assign cur_d = 9'($countones(ram_rdata ^ r_qdesc));
    assign pick  = r_pv_hit ? pc_rdata : 8'd0;
    assign acc   = r_any && (pick < i_k_limit);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_ST_IDLE:   if (i_valid && i_item.op == OP_QUERY) n_state = t_ST_SCAN;
            t_ST_SCAN:   if (issue_done) n_state = t_ST_DRAIN;
            t_ST_DRAIN:  if (!r_rd_v) n_state = t_ST_DECIDE;
            t_ST_DECIDE: n_state = t_ST_IDLE;
            default:     n_state = t_ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop = 1'b0;
        unique case (r_state)
            t_ST_IDLE: o_pop = i_valid;
            default:   o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= t_ST_IDLE;
            r_rd_v   <= 1'b0;
            r_any    <= 1'b0;
            r_pv     <= '0;
            r_tally  <= 16'd0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= 1'b0;
            r_rd_v   <= (r_state == t_ST_SCAN) && !issue_done;
            if (ld_we) begin
                r_pv[ld_addr] <= 1'b1;
                r_tally       <= 16'd0;
            end
            if (r_state == t_ST_IDLE && o_pop && i_item.op == OP_QUERY) begin
                r_any <= 1'b0;
            end
            if (r_rd_v && (!r_any || cur_d < r_best_d)) begin
                r_any <= 1'b1;
            end
            if (r_state == t_ST_DECIDE) begin
                o_strobe <= 1'b1;
                if (acc) begin
                    r_pv[r_best_i] <= 1'b1;
                    r_tally        <= r_tally + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pv_hit <= r_pv[r_best_i];
        if (r_state == t_ST_IDLE && o_pop && i_item.op == OP_QUERY) begin
            r_qdesc <= i_item.desc[DESC_BITS-1:0];
            r_qid   <= i_item.query_id;
            r_issue <= '0;
            r_limit <= lim_sat;
        end
        if (r_state == t_ST_SCAN && !issue_done) begin
            r_issue  <= r_issue + SW'(1);
            r_rd_idx <= AW'(r_issue);
        end
        if (r_rd_v && (!r_any || cur_d < r_best_d)) begin
            r_best_d <= cur_d;
            r_best_i <= r_rd_idx;
        end
        if (r_state == t_ST_DECIDE) begin
            o_found         <= r_any;
            o_accepted      <= acc;
            o_best_entry    <= r_any ? 8'(r_best_i) : 8'd0;
            o_distance      <= r_any ? r_best_d : 9'd0;
            o_column_number <= acc ? (i_first_column + r_tally) : 16'd0;
            o_query_echo    <= r_qid;
        end
    end

    `HNM_ASSERT_IMPL(a_pop_idle, i_clk, i_rst_n, o_pop, r_state == t_ST_IDLE)
    `HNM_ASSERT_NEXT(a_strobe_after_decide, i_clk, i_rst_n, r_state == t_ST_DECIDE, o_strobe)
    `HNM_ASSERT_IMPL(a_read_in_scan, i_clk, i_rst_n, r_rd_v, r_state == t_ST_SCAN)
endmodule

// ===== hdl/hamming_nearest_capped_match_unit.sv =====
// ----------------------------------------------------------------------------
// hamming_nearest_capped_match_unit
// Brute force Hamming nearest neighbor with a per-entry pick limit.
// ----------------------------------------------------------------------------
// A load beat is written in the back end's idle state. A query is popped in
// idle, reads the model RAM one entry per cycle through a single read port
// for min(model_count, MAX_MODELS) entries, sees the scan is done, and passes
// drain and decide. Beats are taken whenever busy is low (the two entry
// queue is not full). Each query gives one o_strobe pulse one cycle wide,
// right after its decide cycle, that the receiver must take; loads give none.
module hamming_nearest_capped_match_unit
    import hnm_pkg::*;
#(
    parameter int DESC_BITS  = DESC_BITS_DEF,
    parameter int MAX_MODELS = MAX_MODELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [7:0]  i_entry_index,
    input  logic [15:0] i_query_id,
    input  logic [63:0] i_word0,
    input  logic [63:0] i_word1,
    input  logic [63:0] i_word2,
    input  logic [63:0] i_word3,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic        o_found,
    output logic        o_accepted,
    output logic [7:0]  o_best_entry,
    output logic [8:0]  o_distance,
    output logic [15:0] o_column_number,
    output logic [15:0] o_query_echo
);
    logic [7:0]  r_k_limit;
    logic [8:0]  r_model_count;
    logic [15:0] r_first_column;
    t_item       in_item, q_item;
    logic        push, full, q_valid, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_limit      <= 8'd1;
            r_model_count  <= 9'd0;
            r_first_column <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_K_LIMIT:      r_k_limit      <= i_cfg_data[7:0];
                REG_MODEL_COUNT:  r_model_count  <= i_cfg_data[8:0];
                REG_FIRST_COLUMN: r_first_column <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = full;
    assign push = start && !full;
    assign in_item.op          = i_op;
    assign in_item.entry_index = i_entry_index;
    assign in_item.query_id    = i_query_id;
    assign in_item.desc        = {i_word3, i_word2, i_word1, i_word0};

    hnm_front #(.DESC_BITS(DESC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    hnm_back #(.DESC_BITS(DESC_BITS), .MAX_MODELS(MAX_MODELS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_item          (q_item),
        .o_pop           (pop),
        .i_k_limit       (r_k_limit),
        .i_model_count   (r_model_count),
        .i_first_column  (r_first_column),
        .o_strobe        (o_strobe),
        .o_found         (o_found),
        .o_accepted      (o_accepted),
        .o_best_entry    (o_best_entry),
        .o_distance      (o_distance),
        .o_column_number (o_column_number),
        .o_query_echo    (o_query_echo)
    );
endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the hamming nearest capped match unit
// Loads model descriptors, runs queries under several limit, count and
// column settings, and checks each result strobe against a model of the
// nearest search, pick limit and column tally kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import hnm_pkg::*;

    typedef struct packed {
        logic        found;
        logic        accepted;
        logic [7:0]  best_entry;
        logic [8:0]  distance;
        logic [15:0] column_number;
        logic [15:0] query_echo;
    } t_match;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_op = OP_LOAD;
    logic [7:0]  i_entry_index = '0;
    logic [15:0] i_query_id = '0;
    logic [63:0] i_word0 = '0, i_word1 = '0, i_word2 = '0, i_word3 = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_K_LIMIT;
    logic [15:0] i_cfg_data = '0;
    logic        o_strobe, o_found, o_accepted;
    logic [7:0]  o_best_entry;
    logic [8:0]  o_distance;
    logic [15:0] o_column_number, o_query_echo;

    hamming_nearest_capped_match_unit DUT (.*);

    always #1 i_clk = ~i_clk;

    // bench copy of the block state
    logic [255:0] model_mem [256];
    logic [7:0]   picks [256];
    logic [15:0]  tally;
    logic [7:0]   k_lim;
    logic [8:0]   n_models;
    logic [15:0]  col_base;
    int           loaded_prefix;   // entries 0..loaded_prefix-1 are written
    bit           written [256];

    t_match match_q [$];
    int     errors = 0;
    int     cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_match nearest_match(logic [15:0] qid, logic [255:0] desc);
        t_match r;
        int     lim, best, bd, d;
        r = '0;
        r.query_echo = qid;
        lim = (n_models > 256) ? 256 : n_models;
        best = 0;
        bd = 1000;
        for (int i = 0; i < lim; i++) begin
            d = $countones(model_mem[i] ^ desc);
            if (d < bd) begin
                bd = d;
                best = i;
            end
        end
        if (lim == 0) return r;
        r.found = 1'b1;
        r.best_entry = best[7:0];
        r.distance = bd[8:0];
        if (picks[best] < k_lim) begin
            picks[best] = picks[best] + 8'd1;
            r.accepted = 1'b1;
            r.column_number = col_base + tally;
            tally = tally + 16'd1;
        end
        return r;
    endfunction

    // result beats are stable mid-cycle
    always @(negedge i_clk) begin
        t_match got, exp_m;
        if (i_rst_n && o_strobe) begin
            got = {o_found, o_accepted, o_best_entry, o_distance,
                   o_column_number, o_query_echo};
            if (match_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
            end else begin
                exp_m = match_q.pop_front();
                if (got.found !== exp_m.found) begin
                    $display("%0t: found exp %h got %h", $time, exp_m.found, got.found);
                    errors++;
                end
                if (got.accepted !== exp_m.accepted) begin
                    $display("%0t: accepted exp %h got %h", $time,
                             exp_m.accepted, got.accepted);
                    errors++;
                end
                if (got.best_entry !== exp_m.best_entry) begin
                    $display("%0t: best_entry exp %h got %h", $time,
                             exp_m.best_entry, got.best_entry);
                    errors++;
                end
                if (got.distance !== exp_m.distance) begin
                    $display("%0t: distance exp %h got %h", $time,
                             exp_m.distance, got.distance);
                    errors++;
                end
                if (got.column_number !== exp_m.column_number) begin
                    $display("%0t: column_number exp %h got %h", $time,
                             exp_m.column_number, got.column_number);
                    errors++;
                end
                if (got.query_echo !== exp_m.query_echo) begin
                    $display("%0t: query_echo exp %h got %h", $time,
                             exp_m.query_echo, got.query_echo);
                    errors++;
                end
            end
        end
    end

    // called at a rising edge; leaves start high after the beat is taken
    task automatic send_item(logic op, logic [7:0] idx, logic [15:0] qid,
                             logic [255:0] desc);
        bit     taken;
        t_match m;
        start <= 1'b1;
        i_op <= op;
        i_entry_index <= idx;
        i_query_id <= qid;
        {i_word3, i_word2, i_word1, i_word0} <= desc;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        if (op == OP_LOAD) begin
            model_mem[idx] = desc;
            picks[idx] = '0;
            tally = '0;
            written[idx] = 1'b1;
            while (loaded_prefix < 256 && written[loaded_prefix]) loaded_prefix++;
        end else begin
            m = nearest_match(qid, desc);
            match_q.insert(match_q.size(), m);
        end
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait for all results, then let trailing loads drain
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (match_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_K_LIMIT:      k_lim = val[7:0];
            REG_MODEL_COUNT:  n_models = val[8:0];
            REG_FIRST_COLUMN: col_base = val;
            default: ;
        endcase
    endtask

    function automatic logic [255:0] rand_desc();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [255:0] near_desc(int e);
        logic [255:0] d;
        d = model_mem[e];
        repeat ($urandom_range(6, 0)) d[$urandom_range(255, 0)] ^= 1'b1;
        return d;
    endfunction

    task automatic test_directed();
        send_item(OP_QUERY, 8'h00, 16'hffff, '1);  // empty search
        send_item(OP_LOAD, 8'd0, 16'h0, '0);
        send_item(OP_LOAD, 8'd1, 16'h0, '1);
        send_item(OP_LOAD, 8'd2, 16'h0, '1);        // tie with entry 1
        send_item(OP_LOAD, 8'd3, 16'h0, {128'h0, {128{1'b1}}});
        wait_idle();
        cfg_write(REG_MODEL_COUNT, 16'd4);
        cfg_write(REG_FIRST_COLUMN, 16'hffff);     // column wrap
        cfg_write(REG_K_LIMIT, 16'd255);
        send_item(OP_QUERY, 8'h00, 16'h0000, '1);  // tie, lowest index
        send_item(OP_QUERY, 8'h00, 16'h1234, '1);
        send_item(OP_QUERY, 8'h00, 16'h5678, '0);  // exact match
        send_item(OP_QUERY, 8'h00, 16'h0001, {128'h0, {128{1'b1}}});
        wait_idle();
        cfg_write(REG_MODEL_COUNT, 16'd1);
        send_item(OP_QUERY, 8'h00, 16'haaaa, '1);  // distance 256
        wait_idle();
        cfg_write(REG_K_LIMIT, 16'd0);              // never accepted
        cfg_write(REG_MODEL_COUNT, 16'd4);
        send_item(OP_QUERY, 8'h00, 16'h5555, '0);
        wait_idle();
        cfg_write(REG_K_LIMIT, 16'd1);              // limit already reached
        send_item(OP_QUERY, 8'hff, 16'h0002, '0);
        send_item(OP_QUERY, 8'hff, 16'h0003, '0);
        send_item(OP_LOAD, 8'd0, 16'h0, '0);        // clears count and tally
        send_item(OP_QUERY, 8'hff, 16'h0004, '0);
        wait_idle();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < 256; i++) begin
            send_item(OP_LOAD, i[7:0], 16'($urandom), rand_desc());
            if ($urandom_range(3, 0) == 0) idle_gap($urandom_range(3, 1));
        end
        wait_idle();
        cfg_write(REG_MODEL_COUNT, 16'd256);
        cfg_write(REG_K_LIMIT, 16'd2);
        for (int i = 0; i < 4; i++)
            send_item(OP_QUERY, 8'h00, 16'($urandom), near_desc(255));
        wait_idle();
        cfg_write(REG_MODEL_COUNT, 16'h1ff);        // saturates
        send_item(OP_QUERY, 8'h00, 16'($urandom), near_desc(200));
        send_item(OP_QUERY, 8'h00, 16'($urandom), rand_desc());
        wait_idle();
    endtask

    task automatic test_random();
        int burst, mc, sel, e;
        for (int ph = 0; ph < 14; ph++) begin
            wait_idle();
            sel = $urandom_range(9, 0);
            cfg_write(REG_K_LIMIT, sel == 0 ? 16'd0 : sel == 1 ? 16'd255 :
                      16'($urandom_range(4, 1)));
            sel = $urandom_range(19, 0);
            mc = sel == 0 ? 0 : sel == 1 ? 256 : $urandom_range(16, 1);
            cfg_write(REG_MODEL_COUNT, mc[15:0]);
            cfg_write(REG_FIRST_COLUMN, $urandom_range(2, 0) == 0 ?
                      16'($urandom_range(65535, 65520)) : 16'($urandom));
            for (int n = 0; n < 40; ) begin
                burst = $urandom_range(12, 1);
                for (int b = 0; b < burst && n < 40; b++, n++) begin
                    sel = $urandom_range(99, 0);
                    e = $urandom_range(mc == 0 ? 255 : mc - 1, 0);
                    if (sel < 12)
                        send_item(OP_LOAD, 8'($urandom_range(255, 0)), 16'($urandom),
                                  sel < 6 ? rand_desc() : near_desc(e));
                    else
                        send_item(OP_QUERY, 8'($urandom), 16'($urandom),
                                  sel < 75 ? near_desc(e) : rand_desc());
                end
                if ($urandom_range(2, 0) != 0) idle_gap($urandom_range(20, 1));
            end
        end
        wait_idle();
    endtask

    initial begin
        tally = '0;
        k_lim = 8'd1;
        n_models = '0;
        col_base = '0;
        loaded_prefix = 0;
        for (int i = 0; i < 256; i++) begin
            model_mem[i] = '0;
            picks[i] = '0;
            written[i] = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        test_random();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
